// ===== rtl/core/motor_effort_slew_and_drive_flags_unit_defines.svh =====
// assertion macros for the checker file
`ifndef MOTOR_EFFORT_SLEW_AND_DRIVE_FLAGS_UNIT_DEFINES_SVH
`define MOTOR_EFFORT_SLEW_AND_DRIVE_FLAGS_UNIT_DEFINES_SVH

// checked only while out of reset
`define MESDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define MESDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/mesdf_pkg.sv =====
`timescale 1ns / 1ps
package mesdf_pkg;

  localparam int unsigned NumCh     = 3;
  localparam int unsigned EffortW   = 16;
  localparam int unsigned StepW     = 16;
  localparam int unsigned DutyW     = 15;
  localparam int unsigned FlagsW    = 4;
  localparam int unsigned ElapsedW  = 24;
  localparam int unsigned AgeW      = 32;
  localparam int unsigned RegW      = 32;
  localparam int unsigned CfgIdxW   = 3;

  // channel order
  localparam int unsigned ChLeft    = 0;
  localparam int unsigned ChRight   = 1;
  localparam int unsigned ChFlipper = 2;

  // flag bit positions
  localparam int unsigned FlagRev   = 0;
  localparam int unsigned FlagBrake = 1;
  localparam int unsigned FlagCoast = 2;
  localparam int unsigned FlagDecay = 3;

  localparam logic [RegW-1:0]  RampStepRst = 32'd65536;
  localparam logic [DutyW-1:0] DutyMax     = 15'h7fff;
  localparam logic [DutyW-1:0] DutyHalf    = 15'd16384;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RAMP_STEP      = 3'd0,
    CFG_CMD_TIMEOUT    = 3'd1,
    CFG_BRAKE_FAULT    = 3'd2,
    CFG_BRAKE_TIMEOUT  = 3'd3,
    CFG_BRAKE_ZERO_CMD = 3'd4,
    CFG_SLOW_DECAY     = 3'd5
  } cfg_idx_e;

  typedef logic signed [EffortW-1:0] effort_t;

  // per-tick control handed from the prep stage to the channels
  typedef struct packed {
    logic             brake;
    logic [StepW-1:0] step;
  } ctl_t;

endpackage

// ===== rtl/core/mesdf_prep.sv =====
`timescale 1ns / 1ps
module mesdf_prep (
  input  logic                            clk_i,
  input  logic                            load_i,
  input  logic [mesdf_pkg::ElapsedW-1:0]  elapsed_i,
  input  logic [mesdf_pkg::AgeW-1:0]      age_i,
  input  logic                            fault_i,
  input  mesdf_pkg::effort_t              tgt_i [mesdf_pkg::NumCh],
  input  logic [mesdf_pkg::RegW-1:0]      ramp_step_i,
  input  logic [mesdf_pkg::RegW-1:0]      timeout_i,
  input  logic                            brake_fault_i,
  input  logic                            brake_timeout_i,
  input  logic                            brake_zero_i,
  output mesdf_pkg::ctl_t                 ctl_o,
  output mesdf_pkg::effort_t              tgt_o [mesdf_pkg::NumCh]
);

  localparam int unsigned ProdW = mesdf_pkg::ElapsedW + mesdf_pkg::RegW;

  logic [ProdW-1:0]            prod;
  logic                        timed_out;
  mesdf_pkg::ctl_t             ctl_d, ctl_q;
  mesdf_pkg::effort_t          tgt_d [mesdf_pkg::NumCh];
  mesdf_pkg::effort_t          tgt_q [mesdf_pkg::NumCh];

  // slew step: elapsed times ramp, >> 16, saturated
  assign prod = ProdW'(elapsed_i) * ProdW'(ramp_step_i);

  // fault beats timeout; both force zero targets
  assign timed_out = (timeout_i != '0) && (age_i > timeout_i);

  always_comb begin
    if (|prod[ProdW-1:32]) begin
      ctl_d.step = '1;
    end else begin
      ctl_d.step = prod[31:16];
    end
    for (int c = 0; c < mesdf_pkg::NumCh; c++) begin
      tgt_d[c] = (fault_i || timed_out) ? '0 : tgt_i[c];
    end
    if (fault_i) begin
      ctl_d.brake = brake_fault_i;
    end else if (timed_out) begin
      ctl_d.brake = brake_timeout_i;
    end else begin
      ctl_d.brake = brake_zero_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ctl_q <= ctl_d;
      tgt_q <= tgt_d;
    end
  end

  assign ctl_o = ctl_q;
  assign tgt_o = tgt_q;

endmodule

// ===== rtl/core/mesdf_chan.sv =====
`timescale 1ns / 1ps
module mesdf_chan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          upd_i,
  input  mesdf_pkg::effort_t            tgt_i,
  input  mesdf_pkg::ctl_t               ctl_i,
  input  logic                          slow_decay_i,
  output logic [mesdf_pkg::FlagsW-1:0]  flags_o,
  output logic [mesdf_pkg::DutyW-1:0]   duty_o
);

  localparam int unsigned XW = mesdf_pkg::EffortW + 2;

  mesdf_pkg::effort_t      last_d, last_q;
  logic signed [XW-1:0]    last_x, step_x, tgt_x, lo, hi, eff_x, mag_x;
  logic [mesdf_pkg::DutyW-1:0] mag;

  // clamp target into [last - step, last + step]
  always_comb begin
    last_x = XW'(last_q);
    step_x = signed'({2'b00, ctl_i.step});
    tgt_x  = XW'(tgt_i);
    lo     = last_x - step_x;
    hi     = last_x + step_x;
    eff_x  = tgt_x;
    if (tgt_x < lo) begin
      eff_x = lo;
    end
    if (eff_x > hi) begin
      eff_x = hi;
    end
  end

  // result always lies between target and last, so 16 bits hold it
  assign last_d = eff_x[mesdf_pkg::EffortW-1:0];

  // magnitude saturates to full scale for the most negative effort
  always_comb begin
    mag_x = eff_x[XW-1] ? -eff_x : eff_x;
    if (mag_x > XW'(mesdf_pkg::DutyMax)) begin
      mag = mesdf_pkg::DutyMax;
    end else begin
      mag = mag_x[mesdf_pkg::DutyW-1:0];
    end
  end

  // flags and duty
  always_comb begin
    flags_o = '0;
    flags_o[mesdf_pkg::FlagRev]   = eff_x[XW-1];
    flags_o[mesdf_pkg::FlagBrake] = (eff_x == '0) && ctl_i.brake;
    flags_o[mesdf_pkg::FlagCoast] = (eff_x == '0) && !ctl_i.brake;
    flags_o[mesdf_pkg::FlagDecay] = slow_decay_i;
    duty_o = slow_decay_i ? mesdf_pkg::DutyHalf + {1'b0, mag[mesdf_pkg::DutyW-1:1]} : mag;
  end

  // stored effort
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (upd_i) begin
      last_q <= last_d;
    end
  end

endmodule

// ===== rtl/core/motor_effort_slew_and_drive_flags_unit.sv =====
`timescale 1ns / 1ps
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata targets, age, elapsed; tuser fault
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata flags and duty, three channels
// cfg       | in  | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// one drive tick per cycle sustained while m_axis is not stalled; the result passes the input
// register (loaded on the transfer), then the step/target and result registers
// the stored effort per channel closes its loop in the last stage, updated with the result register
// reset clears config to defaults, stored efforts to zero, all valids low
// a stall on m_axis freezes the whole pipeline; s_axis_tready follows it
module motor_effort_slew_and_drive_flags_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [mesdf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mesdf_pkg::RegW-1:0]     cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [23:0] elapsed_ticks, [55:24] command_age_ticks, [71:56] target_left,
  // [87:72] target_right, [103:88] target_flipper
  input  logic [103:0]                   s_axis_tdata,
  // [0] system_fault
  input  logic                           s_axis_tuser,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [3:0] flags_left, [18:4] duty_left, [22:19] flags_right, [37:23] duty_right,
  // [41:38] flags_flipper, [56:42] duty_flipper, [63:57] zero
  output logic [63:0]                    m_axis_tdata
);

  localparam int unsigned NumCh = mesdf_pkg::NumCh;
  localparam int unsigned ChW   = mesdf_pkg::FlagsW + mesdf_pkg::DutyW;

  // config registers
  logic [mesdf_pkg::RegW-1:0] ramp_step_q, timeout_q;
  logic brake_fault_q, brake_timeout_q, brake_zero_q, slow_decay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q     <= mesdf_pkg::RampStepRst;
      timeout_q       <= '0;
      brake_fault_q   <= 1'b0;
      brake_timeout_q <= 1'b0;
      brake_zero_q    <= 1'b0;
      slow_decay_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mesdf_pkg::CFG_RAMP_STEP:      ramp_step_q     <= cfg_data_i;
        mesdf_pkg::CFG_CMD_TIMEOUT:    timeout_q       <= cfg_data_i;
        mesdf_pkg::CFG_BRAKE_FAULT:    brake_fault_q   <= cfg_data_i[0];
        mesdf_pkg::CFG_BRAKE_TIMEOUT:  brake_timeout_q <= cfg_data_i[0];
        mesdf_pkg::CFG_BRAKE_ZERO_CMD: brake_zero_q    <= cfg_data_i[0];
        mesdf_pkg::CFG_SLOW_DECAY:     slow_decay_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless the result is stalled
  logic adv;
  logic a_valid_q, b_valid_q, m_valid_q;

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= s_axis_tvalid;
      b_valid_q <= a_valid_q;
      m_valid_q <= b_valid_q;
    end
  end

  // input register
  logic [mesdf_pkg::ElapsedW-1:0] elapsed_q;
  logic [mesdf_pkg::AgeW-1:0]     age_q;
  logic                           fault_q;
  mesdf_pkg::effort_t             tgt_q [NumCh];

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      elapsed_q <= s_axis_tdata[23:0];
      age_q     <= s_axis_tdata[55:24];
      fault_q   <= s_axis_tuser;
      for (int c = 0; c < NumCh; c++) begin
        tgt_q[c] <= s_axis_tdata[56 + c*mesdf_pkg::EffortW +: mesdf_pkg::EffortW];
      end
    end
  end

  // step and target selection
  mesdf_pkg::ctl_t    ctl;
  mesdf_pkg::effort_t tgt_b [NumCh];

  mesdf_prep u_prep (
    .clk_i           (clk_i),
    .load_i          (adv && a_valid_q),
    .elapsed_i       (elapsed_q),
    .age_i           (age_q),
    .fault_i         (fault_q),
    .tgt_i           (tgt_q),
    .ramp_step_i     (ramp_step_q),
    .timeout_i       (timeout_q),
    .brake_fault_i   (brake_fault_q),
    .brake_timeout_i (brake_timeout_q),
    .brake_zero_i    (brake_zero_q),
    .ctl_o           (ctl),
    .tgt_o           (tgt_b)
  );

  // per-channel slew limit and drive flags
  logic                  upd;
  logic [ChW*NumCh-1:0]  res_d, res_q;

  assign upd = adv && b_valid_q;

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    logic [mesdf_pkg::FlagsW-1:0] flags;
    logic [mesdf_pkg::DutyW-1:0]  duty;
    logic [ChW-1:0]               slot;

    mesdf_chan u_chan (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .upd_i        (upd),
      .tgt_i        (tgt_b[c]),
      .ctl_i        (ctl),
      .slow_decay_i (slow_decay_q),
      .flags_o      (flags),
      .duty_o       (duty)
    );

    // right channel reverse sense is inverted
    always_comb begin
      slot[mesdf_pkg::FlagsW-1:0] = flags;
      if (c == mesdf_pkg::ChRight) begin
        slot[mesdf_pkg::FlagRev] = !flags[mesdf_pkg::FlagRev];
      end
      slot[mesdf_pkg::FlagsW +: mesdf_pkg::DutyW] = duty;
    end

    assign res_d[c*ChW +: ChW] = slot;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (upd) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(64 - ChW*NumCh)'(0), res_q};

endmodule

// ===== rtl/core/mesdf_checker.sv =====
`timescale 1ns / 1ps
`include "motor_effort_slew_and_drive_flags_unit_defines.svh"
module mesdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // a stalled result keeps its data
  `MESDF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // no result once reset has been seen
  `MESDF_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !m_axis_tvalid, "result valid in reset")

  // input side is open whenever the result slot is free or draining
  `MESDF_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready mismatch")

  // decay flag is common to all channels, brake and coast exclusive on left
  `MESDF_ASSERT(a_flags, m_axis_tvalid |-> (m_axis_tdata[3] == m_axis_tdata[22]) && (m_axis_tdata[3] == m_axis_tdata[41]) && !(m_axis_tdata[1] && m_axis_tdata[2]), "inconsistent flags")

  // fast decay: left duty is zero exactly when brake or coast is set
  `MESDF_ASSERT(a_duty_zero, m_axis_tvalid && !m_axis_tdata[3] |-> ((m_axis_tdata[18:4] == 15'd0) == (m_axis_tdata[1] || m_axis_tdata[2])), "duty and stop flag disagree")

endmodule

bind motor_effort_slew_and_drive_flags_unit mesdf_checker u_mesdf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
